// ===== rtl/fbba_pkg.sv =====
// ----------------------------------------------------------------------------
// fbba_pkg
// Shared types, codes and helpers for the file block bitmap allocator.
// ----------------------------------------------------------------------------
package fbba_pkg;

	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	localparam logic [1:0] K_CLAIM = 2'd0;
	localparam logic [1:0] K_FREE  = 2'd1;
	localparam logic [1:0] K_DONE  = 2'd2;
	localparam logic [1:0] K_XLAT  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOSPACE  = 2'd1;
	localparam logic [1:0] ST_TOOLARGE = 2'd2;
	localparam logic [1:0] ST_BEYOND   = 2'd3;

	localparam logic REG_RESERVED = 1'b0;

	typedef logic [WORD_W-1:0] word_t;

	function automatic logic [BIT_W:0] pop_count(input word_t w);
		logic [BIT_W:0] s;
		s = '0;
		for (int j = 0; j < WORD_W; j++) begin
			s = s + {{BIT_W{1'b0}}, w[j]};
		end
		return s;
	endfunction

	function automatic logic [BIT_W-1:0] low_bit(input word_t w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (w[j]) begin
				r = BIT_W'(j);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/fbba_bitmap.sv =====
// ----------------------------------------------------------------------------
// fbba_bitmap
// Block-in-use bitmap RAM, one word of blocks per row, with a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
module fbba_bitmap import fbba_pkg::*; #(
	parameter int NROWS = 32,
	parameter int RW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [RW-1:0] rd_row,
	output word_t         rd_data,
	input  logic          wr_en,
	input  logic [RW-1:0] wr_row,
	input  word_t         wr_data,
	output logic          busy
);

	word_t         mem [NROWS];
	word_t         rd_data_q;
	logic          busy_q;
	logic [RW-1:0] clr_row_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_row_q] <= '0;
		end else if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		rd_data_q <= mem[rd_row];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_row_q <= '0;
		end else if (busy_q) begin
			if (clr_row_q == RW'(NROWS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_row_q <= clr_row_q + 1'b1;
			end
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

// ===== rtl/file_block_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// file_block_bitmap_allocator_unit
// First-fit bitmap block allocator for a small file table.
// ----------------------------------------------------------------------------
// One item at a time; s_tready is low while an item is worked on. A small
// sequencer drives one shared adder/comparator for the byte-to-block rounding
// and the offset-to-position step, which count blocks one at a time (up to
// MAX_BLOCKS_PER_FILE+1). A file index of NUM_FILES or more is reduced by
// repeated subtraction of NUM_FILES. Growth counts free blocks over the whole
// bitmap one 32-block row at a time, then claims free blocks row by row.
// Shrinking frees blocks one at a time, the last claimed first. After reset
// a clearing pass over all ceil(NUM_BLOCKS/32) bitmap rows runs before the
// first item is taken. Output results leave through a register and stall the
// sequencer only when the output is backed up.
module file_block_bitmap_allocator_unit import fbba_pkg::*; #(
	parameter int NUM_BLOCKS          = 1024,
	parameter int BLOCK_BYTES         = 4096,
	parameter int NUM_FILES           = 64,
	parameter int MAX_BLOCKS_PER_FILE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[0], file_index[6:1], new_size[23:7], byte_offset[39:24]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// block_number[9:0], status[11:10], file_size[28:12], zero[31:29]
	output logic [31:0] m_tdata,
	// kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	localparam int MAXB   = MAX_BLOCKS_PER_FILE;
	localparam int NROWS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int RW     = NROWS > 1 ? $clog2(NROWS) : 1;
	localparam int BW     = $clog2(NUM_BLOCKS);
	localparam int FW     = NUM_FILES > 1 ? $clog2(NUM_FILES) : 1;
	localparam int LDEPTH = NUM_FILES * MAXB;
	localparam int LW     = LDEPTH > 1 ? $clog2(LDEPTH) : 1;
	localparam int HW     = $clog2(MAXB + 1);
	localparam int CW     = $clog2(MAXB + 2);
	localparam int AW0    = $clog2((MAXB + 2) * BLOCK_BYTES);
	localparam int AW     = AW0 > 18 ? AW0 : 18;
	localparam int AVW    = BW + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MOD    = 4'd1;
	localparam logic [3:0] S_FILE   = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_RES    = 4'd4;
	localparam logic [3:0] S_LRD    = 4'd5;
	localparam logic [3:0] S_CNT_RD = 4'd6;
	localparam logic [3:0] S_CNT_EV = 4'd7;
	localparam logic [3:0] S_CNT_CK = 4'd8;
	localparam logic [3:0] S_CLM_RD = 4'd9;
	localparam logic [3:0] S_CLM_LD = 4'd10;
	localparam logic [3:0] S_CLM    = 4'd11;
	localparam logic [3:0] S_FREE   = 4'd12;
	localparam logic [3:0] S_FREE_L = 4'd13;
	localparam logic [3:0] S_FREE_B = 4'd14;
	localparam logic [3:0] S_DONE   = 4'd15;

	logic [3:0]     state_q;
	logic [10:0]    reserved_q;
	logic           act_q;
	logic [5:0]     f_q;
	logic [16:0]    nsize_q;
	logic [15:0]    off_q;
	logic [16:0]    cur_q;
	logic [HW-1:0]  held_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  want_q;
	logic [AW-1:0]  acc_q;
	logic [AVW-1:0] avail_q;
	logic [RW-1:0]  row_q;
	word_t          w_q;
	logic [BW-1:0]  blk_q;

	logic [16:0]    fsize_mem [NUM_FILES];
	logic [HW-1:0]  fheld_mem [NUM_FILES];
	logic [16:0]    fsize_rd_q;
	logic [HW-1:0]  fheld_rd_q;
	logic [NUM_FILES-1:0] fvalid_q;
	logic [BW-1:0]  list_mem [LDEPTH];
	logic [BW-1:0]  lst_rd_q;

	logic           m_tvalid_q;
	logic [1:0]     o_kind_q;
	logic [9:0]     o_blk_q;
	logic [1:0]     o_st_q;
	logic [16:0]    o_size_q;
	logic           o_last_q;

	logic [FW-1:0]  fidx;
	logic           can_emit;
	logic           em;
	logic [1:0]     em_kind;
	logic [BW-1:0]  em_blk;
	logic [1:0]     em_st;
	logic [16:0]    em_size;
	logic           em_last;
	logic           fm_wr;
	logic           lst_wr;
	logic [LW-1:0]  lst_wr_addr;
	logic [LW-1:0]  lst_rd_addr;
	logic [RW-1:0]  bm_rd_row;
	word_t          bm_rd_data;
	logic           bm_wr_en;
	logic [RW-1:0]  bm_wr_row;
	word_t          bm_wr_data;
	logic           bm_busy;
	word_t          ok_mask;
	word_t          free_rd;
	word_t          free_w;
	logic [BIT_W-1:0] pick;
	logic [BW-1:0]  pick_blk;
	logic [BIT_W-1:0] fbit;
	logic           div_step;
	logic           s_acc;
	logic           cfg_wr;

	assign fidx     = FW'(f_q);
	assign can_emit = !m_tvalid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite;

	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			ok_mask[j] = (int'(row_q) * WORD_W + j >= int'(reserved_q)) &&
				(int'(row_q) * WORD_W + j < NUM_BLOCKS);
		end
	end

	assign free_rd  = ~bm_rd_data & ok_mask;
	assign free_w   = ~w_q & ok_mask;
	assign pick     = low_bit(free_w);
	assign pick_blk = BW'(int'(row_q) * WORD_W + int'(pick));
	assign fbit     = BIT_W'(blk_q);

	assign div_step = act_q ?
		((AW'(off_q) >= acc_q) && (int'(cnt_q) < int'(held_q))) :
		((acc_q < AW'(nsize_q)) && (int'(cnt_q) <= MAXB));

	always_comb begin
		em          = 1'b0;
		em_kind     = K_DONE;
		em_blk      = '0;
		em_st       = ST_OK;
		em_size     = cur_q;
		em_last     = 1'b1;
		fm_wr       = 1'b0;
		lst_wr      = 1'b0;
		lst_wr_addr = LW'(int'(fidx) * MAXB + int'(held_q));
		lst_rd_addr = LW'(int'(fidx) * MAXB + int'(cnt_q));
		bm_rd_row   = row_q;
		bm_wr_en    = 1'b0;
		bm_wr_row   = row_q;
		bm_wr_data  = w_q;
		case (state_q)
			S_RES: begin
				if (act_q) begin
					if (AW'(off_q) >= AW'(cur_q) || int'(cnt_q) >= int'(held_q)) begin
						em      = can_emit;
						em_kind = K_XLAT;
						em_st   = ST_BEYOND;
					end
				end else if (nsize_q == cur_q) begin
					em = can_emit;
				end else if (int'(cnt_q) > MAXB) begin
					em    = can_emit;
					em_st = ST_TOOLARGE;
				end
			end
			S_LRD: begin
				em      = can_emit;
				em_kind = K_XLAT;
				em_blk  = lst_rd_q;
			end
			S_CNT_CK: begin
				if (int'(avail_q) < int'(want_q) - int'(held_q)) begin
					em    = can_emit;
					em_st = ST_NOSPACE;
				end
			end
			S_CLM: begin
				if (CW'(held_q) == want_q || free_w == '0) begin
					bm_wr_en = 1'b1;
				end else if (can_emit) begin
					em      = 1'b1;
					em_kind = K_CLAIM;
					em_blk  = pick_blk;
					em_size = nsize_q;
					em_last = 1'b0;
					lst_wr  = 1'b1;
				end
			end
			S_FREE: begin
				lst_rd_addr = LW'(int'(fidx) * MAXB + int'(held_q) - 1);
			end
			S_FREE_L: begin
				bm_rd_row = RW'(lst_rd_q >> BIT_W);
			end
			S_FREE_B: begin
				bm_rd_row  = RW'(blk_q >> BIT_W);
				bm_wr_row  = RW'(blk_q >> BIT_W);
				bm_wr_data = bm_rd_data & ~(word_t'(1) << fbit);
				if (can_emit) begin
					bm_wr_en = 1'b1;
					em       = 1'b1;
					em_kind  = K_FREE;
					em_blk   = blk_q;
					em_size  = nsize_q;
					em_last  = 1'b0;
				end
			end
			S_DONE: begin
				if (can_emit) begin
					em      = 1'b1;
					em_size = nsize_q;
					fm_wr   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			reserved_q <= '0;
			fvalid_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr && paddr[2] == REG_RESERVED) begin
				reserved_q <= pwdata[10:0];
			end
			if (fm_wr) begin
				fvalid_q[fidx] <= 1'b1;
			end
			if (em) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (s_acc) state_q <= S_MOD;
				S_MOD: if (int'(f_q) < NUM_FILES) state_q <= S_FILE;
				S_FILE: state_q <= S_DIV;
				S_DIV: if (!div_step) state_q <= S_RES;
				S_RES: begin
					if (em) begin
						state_q <= S_IDLE;
					end else if (act_q) begin
						if (AW'(off_q) < AW'(cur_q) && int'(cnt_q) < int'(held_q)) begin
							state_q <= S_LRD;
						end
					end else if (nsize_q != cur_q && int'(cnt_q) <= MAXB) begin
						state_q <= (int'(cnt_q) > int'(held_q)) ? S_CNT_RD : S_FREE;
					end
				end
				S_LRD: if (em) state_q <= S_IDLE;
				S_CNT_RD: state_q <= S_CNT_EV;
				S_CNT_EV: state_q <= (row_q == RW'(NROWS - 1)) ? S_CNT_CK : S_CNT_RD;
				S_CNT_CK: begin
					if (em) begin
						state_q <= S_IDLE;
					end else if (int'(avail_q) >= int'(want_q) - int'(held_q)) begin
						state_q <= S_CLM_RD;
					end
				end
				S_CLM_RD: state_q <= S_CLM_LD;
				S_CLM_LD: state_q <= S_CLM;
				S_CLM: begin
					if (CW'(held_q) == want_q) begin
						state_q <= S_DONE;
					end else if (free_w == '0) begin
						state_q <= S_CLM_RD;
					end
				end
				S_FREE: state_q <= (CW'(held_q) > want_q) ? S_FREE_L : S_DONE;
				S_FREE_L: state_q <= S_FREE_B;
				S_FREE_B: if (em) state_q <= S_FREE;
				S_DONE: if (em) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q   <= s_tdata[0];
				f_q     <= s_tdata[6:1];
				nsize_q <= s_tdata[23:7];
				off_q   <= s_tdata[39:24];
			end
			S_MOD: begin
				if (int'(f_q) >= NUM_FILES) begin
					f_q <= 6'(int'(f_q) - NUM_FILES);
				end
			end
			S_FILE: begin
				cur_q  <= fvalid_q[fidx] ? fsize_rd_q : '0;
				held_q <= fvalid_q[fidx] ? fheld_rd_q : '0;
				acc_q  <= act_q ? AW'(BLOCK_BYTES) : '0;
				cnt_q  <= '0;
			end
			S_DIV: begin
				if (div_step) begin
					acc_q <= acc_q + AW'(BLOCK_BYTES);
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_RES: begin
				want_q  <= cnt_q;
				avail_q <= '0;
				row_q   <= '0;
			end
			S_CNT_EV: begin
				avail_q <= avail_q + AVW'(pop_count(free_rd));
				row_q   <= row_q + 1'b1;
			end
			S_CNT_CK: row_q <= '0;
			S_CLM_LD: w_q <= bm_rd_data;
			S_CLM: begin
				if (CW'(held_q) != want_q) begin
					if (free_w == '0) begin
						row_q <= row_q + 1'b1;
					end else if (can_emit) begin
						w_q[pick] <= 1'b1;
						held_q    <= held_q + 1'b1;
					end
				end
			end
			S_FREE_L: blk_q <= lst_rd_q;
			S_FREE_B: if (can_emit) held_q <= held_q - 1'b1;
			default: begin
			end
		endcase
		if (em) begin
			o_kind_q <= em_kind;
			o_blk_q  <= 10'(em_blk);
			o_st_q   <= em_st;
			o_size_q <= em_size;
			o_last_q <= em_last;
		end
	end

	always_ff @(posedge clk) begin
		if (fm_wr) begin
			fsize_mem[fidx] <= nsize_q;
			fheld_mem[fidx] <= held_q;
		end
		fsize_rd_q <= fsize_mem[fidx];
		fheld_rd_q <= fheld_mem[fidx];
	end

	always_ff @(posedge clk) begin
		if (lst_wr) begin
			list_mem[lst_wr_addr] <= pick_blk;
		end
		lst_rd_q <= list_mem[lst_rd_addr];
	end

	fbba_bitmap #(
		.NROWS (NROWS),
		.RW    (RW)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_row  (bm_rd_row),
		.rd_data (bm_rd_data),
		.wr_en   (bm_wr_en),
		.wr_row  (bm_wr_row),
		.wr_data (bm_wr_data),
		.busy    (bm_busy)
	);

	assign s_tready = (state_q == S_IDLE) && !bm_busy;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, o_size_q, o_st_q, o_blk_q};
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_RESERVED) ? {21'd0, reserved_q} : 32'd0;

endmodule
